### hdl/pcts_pkg.sv
// Package: shared types, widths and constants of the periodic compare timer.
package pcts_pkg;

    localparam int DEF_NUM_SLOTS   = 4;
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int MAX_RESULTS     = 4;

    localparam int OP_W     = 2;
    localparam int ID_W     = 3;
    localparam int PERIOD_W = 16;
    localparam int CHAN_W   = 2;
    localparam int TIME_W   = 16;
    localparam int STAT_W   = 2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] CFG_MIN_PERIOD = 1'b0;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = 16'd4;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_REG   = 2'd1,
        OP_UNREG = 2'd2,
        OP_MOD   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_FULL  = 2'd2,
        ST_BADID = 2'd3
    } stat_t;

    typedef struct packed {
        logic [OP_W-1:0]     opcode;
        logic [ID_W-1:0]     slot_id;
        logic [PERIOD_W-1:0] period;
    } cmd_t;

    // batch handed from the core to the serializer
    typedef struct packed {
        logic              load;
        logic              rep;
        logic [CHAN_W-1:0] chan;
        stat_t             status;
    } bat_ctl_t;

endpackage

### hdl/pcts_if.sv
// Interfaces: command channel and result channel with valid/ready handshake.
interface pcts_cmd_if import pcts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    logic [ID_W-1:0]     slot_id;
    logic [PERIOD_W-1:0] period;

    modport source (output valid, output opcode, output slot_id, output period, input ready);
    modport sink (input valid, input opcode, input slot_id, input period, output ready);
endinterface

interface pcts_res_if import pcts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [CHAN_W-1:0] channel;
    logic [TIME_W-1:0] event_time;
    logic [STAT_W-1:0] status;
    logic              last;

    modport source (output valid, output kind, output channel, output event_time,
                    output status, output last, input ready);
    modport sink (input valid, input kind, input channel, input event_time,
                  input status, input last, output ready);
endinterface

### hdl/periodic_compare_timer_slots.sv
// Top level: periodic output-compare timer with four slots by default.
// Usage:
//   cmd channel takes one item per request: opcode tick, register, unregister
//   or modify, with slot_id and period. res channel returns results: one reply
//   (kind 1, last 1) per request, and zero to four firing events per tick, in
//   slot order, with last on the final one. A tick with nothing due gives none.
//   min_period is set over the APB port at byte address 0, while idle.
// Timing:
//   An accepted item is held in the command register, is evaluated in a single
//   pass once the serializer is free, and its batch is registered in the result
//   serializer, which presents it on res. The events of a tick leave the
//   serializer one per accepted result, and the next item waits in the command
//   register until the batch has drained. cmd is accepted while a batch drains.
// Reset: counter zero, all slots inactive, min_period 4, no result pending.
// Stall: while res.ready is low the current result holds, one more item is
//   buffered in the command register, then cmd.ready drops.
module periodic_compare_timer_slots import pcts_pkg::*; #(
    parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    pcts_cmd_if.sink          cmd,
    pcts_res_if.source        res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [PERIOD_W-1:0]  min_period_reg;
    logic                 ser_free;
    bat_ctl_t             ctl;
    logic [NUM_SLOTS-1:0] mask;
    logic [TIME_W-1:0]    times [NUM_SLOTS];
    logic                 hit;

    assign pready = 1'b1;
    assign hit    = (paddr[APB_AW-1:2] == CFG_MIN_PERIOD);
    assign prdata = hit ? APB_DW'(min_period_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_period_reg <= MIN_PERIOD_RST;
        else if (psel && penable && pwrite && pready && hit)
            min_period_reg <= pwdata[PERIOD_W-1:0];
    end

    pcts_core #(
        .NUM_SLOTS   (NUM_SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .min_period (min_period_reg),
        .ser_free   (ser_free),
        .ctl        (ctl),
        .mask       (mask),
        .times      (times)
    );

    pcts_ser #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .mask     (mask),
        .times    (times),
        .res      (res),
        .ser_free (ser_free)
    );

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> ser_free)
        else $error("batch loaded while serializer busy");

    a_rep_single: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.kind |-> res.last)
        else $error("reply not marked last");

    a_batch_cont: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.ready && !res.last |=> res.valid && !res.kind)
        else $error("event batch broken before last");

    a_rep_shown: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load && ctl.rep |=> res.valid && res.kind)
        else $error("reply not presented after load");

endmodule

### hdl/pcts_core.sv
// Core: command register, timer state and single-pass request/tick evaluation.
module pcts_core import pcts_pkg::*; #(
    parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    pcts_cmd_if.sink            cmd,
    input  logic [PERIOD_W-1:0] min_period,
    input  logic                ser_free,
    output bat_ctl_t            ctl,
    output logic [NUM_SLOTS-1:0] mask,
    output logic [TIME_W-1:0]   times [NUM_SLOTS]
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic                   cmd_vld_reg;
    cmd_t                   cmd_reg;
    logic [COUNT_WIDTH-1:0] tick_reg;
    logic [COUNT_WIDTH-1:0] next_reg [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] per_reg  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   act_reg;

    logic                   proc;
    op_t                    op;
    logic [COUNT_WIDTH-1:0] tick_next;
    logic [COUNT_WIDTH-1:0] per_c;
    logic [NUM_SLOTS-1:0]   due;
    logic                   free_hit;
    logic [SLOT_W-1:0]      free_idx;
    logic                   id_ok;
    logic [SLOT_W-1:0]      id_idx;
    logic                   reg_ok;

    assign proc      = cmd_vld_reg && ser_free;
    assign cmd.ready = !cmd_vld_reg || ser_free;
    assign op        = op_t'(cmd_reg.opcode);
    assign tick_next = tick_reg + 1'b1;
    assign per_c     = COUNT_WIDTH'(cmd_reg.period);
    assign id_ok     = 32'(cmd_reg.slot_id) < NUM_SLOTS;
    assign id_idx    = SLOT_W'(cmd_reg.slot_id);
    assign reg_ok    = (cmd_reg.period >= min_period) && free_hit;

    always_comb
    begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            due[i]   = act_reg[i] && (next_reg[i] == tick_next);
            times[i] = TIME_W'(next_reg[i]);
            if (!act_reg[i])
            begin
                free_hit = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        ctl.load   = proc;
        ctl.rep    = (op != OP_TICK);
        ctl.chan   = '0;
        ctl.status = ST_OK;
        mask       = '0;
        unique case (op)
            OP_TICK:
            begin
                mask = due;
            end
            OP_REG:
            begin
                if (cmd_reg.period < min_period)
                    ctl.status = ST_SHORT;
                else if (!free_hit)
                    ctl.status = ST_FULL;
                else
                    ctl.chan = CHAN_W'(free_idx);
            end
            OP_UNREG, OP_MOD:
            begin
                if (!id_ok)
                    ctl.status = ST_BADID;
                else
                    ctl.chan = CHAN_W'(id_idx);
            end
            default:
            begin
                ctl.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
            tick_reg    <= '0;
            act_reg     <= '0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                cmd_vld_reg <= 1'b1;
            else if (proc)
                cmd_vld_reg <= 1'b0;
            if (proc)
            begin
                unique case (op)
                    OP_TICK:
                        tick_reg <= tick_next;
                    OP_REG:
                        if (reg_ok)
                            act_reg[free_idx] <= 1'b1;
                    OP_UNREG:
                        if (id_ok)
                            act_reg[id_idx] <= 1'b0;
                    default:
                        act_reg <= act_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg.opcode  <= cmd.opcode;
            cmd_reg.slot_id <= cmd.slot_id;
            cmd_reg.period  <= cmd.period;
        end
        if (proc)
        begin
            unique case (op)
                OP_TICK:
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (due[i])
                            next_reg[i] <= next_reg[i] + per_reg[i];
                OP_REG:
                    if (reg_ok)
                    begin
                        next_reg[free_idx] <= tick_reg + per_c;
                        per_reg[free_idx]  <= per_c;
                    end
                OP_MOD:
                    if (id_ok)
                        per_reg[id_idx] <= per_c;
                default:
                    per_reg <= per_reg;
            endcase
        end
    end

endmodule

### hdl/pcts_ser.sv
// Serializer: holds one batch and puts its results on the result channel.
module pcts_ser import pcts_pkg::*; #(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bat_ctl_t             ctl,
    input  logic [NUM_SLOTS-1:0] mask,
    input  logic [TIME_W-1:0]    times [NUM_SLOTS],
    pcts_res_if.source           res,
    output logic                 ser_free
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SENT_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    logic                 busy_reg;
    logic                 rep_reg;
    logic [NUM_SLOTS-1:0] mask_reg;
    logic [SENT_W-1:0]    sent_reg;
    logic [CHAN_W-1:0]    rep_chan_reg;
    stat_t                rep_stat_reg;
    logic [TIME_W-1:0]    time_reg [NUM_SLOTS];

    logic [SLOT_W-1:0]    cur_idx;
    logic [NUM_SLOTS-1:0] rest;
    logic                 last_c;

    always_comb
    begin
        cur_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
            if (mask_reg[i])
                cur_idx = SLOT_W'(i);
        for (int i = 0; i < NUM_SLOTS; i++)
            rest[i] = mask_reg[i] && (SLOT_W'(i) != cur_idx);
    end

    // a tick shows at most MAX_RESULTS events; the rest are dropped
    assign last_c = rep_reg || (rest == '0) || (sent_reg == SENT_W'(MAX_RESULTS - 1));

    assign res.valid      = busy_reg;
    assign res.kind       = rep_reg;
    assign res.channel    = rep_reg ? rep_chan_reg : CHAN_W'(cur_idx);
    assign res.event_time = rep_reg ? '0 : time_reg[cur_idx];
    assign res.status     = rep_reg ? rep_stat_reg : ST_OK;
    assign res.last       = last_c;
    assign ser_free       = !busy_reg || (res.ready && last_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rep_reg  <= 1'b0;
            mask_reg <= '0;
            sent_reg <= '0;
        end
        else if (ctl.load)
        begin
            busy_reg <= ctl.rep || (mask != '0);
            rep_reg  <= ctl.rep;
            mask_reg <= mask;
            sent_reg <= '0;
        end
        else if (busy_reg && res.ready)
        begin
            if (last_c)
                busy_reg <= 1'b0;
            else
            begin
                mask_reg <= rest;
                sent_reg <= sent_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rep_chan_reg <= ctl.chan;
            rep_stat_reg <= ctl.status;
            time_reg     <= times;
        end
    end

endmodule
